[hdl/rpsd_pkg.sv]
// Shared constants, types and command-decode functions of the RefPack decompressor.
package rpsd_pkg;

    localparam int HIST_AW    = 17;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int DEC_W      = HIST_AW + 1;
    localparam int LANES      = 32;
    localparam int CNT_W      = 6;
    localparam int FILL_AW    = 5;
    localparam int DIST_W     = 18;
    localparam int LEN_W      = 11;
    localparam int LIT_W      = 7;

    localparam logic [7:0] CODE_MEDIUM = 8'h80;
    localparam logic [7:0] CODE_LONG   = 8'hC0;
    localparam logic [7:0] CODE_RUN    = 8'hE0;
    localparam logic [7:0] CODE_END    = 8'hFC;

    typedef struct packed {
        logic              lit_latch;
        logic              lit_emit;
        logic              match_start;
        logic [DIST_W-1:0] back_dist;
        logic [LEN_W-1:0]  len;
        logic              match_step;
        logic              match_emit;
        logic              end_emit;
        logic              run_last;
        logic              stream_end;
        logic              clr_decoded;
    } rpsd_cmd_t;

    typedef struct packed {
        logic out_free;
        logic chunk_ready;
        logic match_done;
    } rpsd_sts_t;

    function automatic logic [1:0] extras_needed(input logic [7:0] code);
        logic [1:0] n;
        if (code < CODE_MEDIUM)
            n = 2'd1;
        else if (code < CODE_LONG)
            n = 2'd2;
        else if (code < CODE_RUN)
            n = 2'd3;
        else
            n = 2'd0;
        return n;
    endfunction

    function automatic logic [LIT_W-1:0] literal_count(input logic [7:0] code,
                                                       input logic [7:0] c2);
        logic [LIT_W-1:0] n;
        if (code < CODE_MEDIUM)
            n = {5'd0, code[1:0]};
        else if (code < CODE_LONG)
            n = {5'd0, c2[7:6]};
        else if (code < CODE_RUN)
            n = {5'd0, code[1:0]};
        else if (code < CODE_END)
            n = {code[4:0] + 5'd1, 2'b00};
        else
            n = {5'd0, code[1:0]};
        return n;
    endfunction

    function automatic logic [DIST_W-1:0] match_dist(input logic [7:0] code,
                                                     input logic [7:0] c2,
                                                     input logic [7:0] c3);
        logic [DIST_W-1:0] d;
        if (code < CODE_MEDIUM)
            d = {8'd0, code[6:5], c2} + DIST_W'(1);
        else if (code < CODE_LONG)
            d = {4'd0, c2[5:0], c3} + DIST_W'(1);
        else
            d = {1'b0, code[4], c2, c3} + DIST_W'(1);
        return d;
    endfunction

    function automatic logic [LEN_W-1:0] match_len(input logic [7:0] code,
                                                   input logic [7:0] c4);
        logic [LEN_W-1:0] l;
        if (code < CODE_MEDIUM)
            l = {8'd0, code[4:2]} + LEN_W'(3);
        else if (code < CODE_LONG)
            l = {5'd0, code[5:0]} + LEN_W'(4);
        else
            l = {1'b0, code[3:2], c4} + LEN_W'(5);
        return l;
    endfunction

endpackage

[hdl/refpack_stream_decompressor_core.sv]
// Top level of the streaming RefPack (QFS) LZ77 decompressor.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall | in_byte
//  out     | output    | out_valid/out_stall | bytes_0_7..bytes_24_31, byte_count,
//          |           |                     | run_last, stream_end, distance_error
//
// Header and command bytes are accepted while the controller is idle; a completed command
// then passes through a dispatch state. A literal byte is accepted, then written and emitted.
// A match copies each byte through the single history memory (registered read, then
// write) and emits every chunk of up to 32 bytes in an emit state of its own.
// rst_n clears all control state; the 128 KiB history is not cleared and is never
// read before it is written. out_stall holds the output register and the controller
// waits for it before each new transaction; in_stall is high whenever the core is busy.
module refpack_stream_decompressor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] bytes_0_7,
    output logic [63:0] bytes_8_15,
    output logic [63:0] bytes_16_23,
    output logic [63:0] bytes_24_31,
    output logic [5:0]  byte_count,
    output logic        run_last,
    output logic        stream_end,
    output logic        distance_error
);

    rpsd_pkg::rpsd_cmd_t cmd;
    rpsd_pkg::rpsd_sts_t sts;
    logic [8*rpsd_pkg::LANES-1:0] out_data;

    // parser and sequencer
    rpsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // history, copy engine and output register
    rpsd_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_byte        (in_byte),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .out_count      (byte_count),
        .out_run_last   (run_last),
        .out_stream_end (stream_end),
        .out_dist_err   (distance_error)
    );

    // chunk lanes, byte 0 in the low bits
    assign bytes_0_7   = out_data[63:0];
    assign bytes_8_15  = out_data[127:64];
    assign bytes_16_23 = out_data[191:128];
    assign bytes_24_31 = out_data[255:192];

    // a failed back-reference delivers only zero bytes
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && distance_error) |-> (out_data == '0))
        else $error("distance error chunk carries nonzero data");

    // end of stream is always the last transaction of its input byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stream_end) |-> run_last)
        else $error("stream_end without run_last");

    // an empty chunk only comes from an end code without literals
    a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (byte_count == 6'd0)) |-> stream_end)
        else $error("empty chunk outside stream end");

    // no input is taken while a match is still being copied
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.match_step || cmd.match_emit) |-> in_stall)
        else $error("input accepted during match copy");

endmodule

[hdl/rpsd_ctrl.sv]
// Controller: header/command parsing and sequencing of literal, match and end transactions.
module rpsd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    output logic               in_stall,
    input  rpsd_pkg::rpsd_sts_t sts,
    output rpsd_pkg::rpsd_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DISP  = 3'd1;
    localparam logic [2:0] ST_LIT   = 3'd2;
    localparam logic [2:0] ST_MRD   = 3'd3;
    localparam logic [2:0] ST_MWR   = 3'd4;
    localparam logic [2:0] ST_MEMIT = 3'd5;
    localparam logic [2:0] ST_END   = 3'd6;

    localparam logic [2:0] PH_HDR0  = 3'd0;
    localparam logic [2:0] PH_HDR1  = 3'd1;
    localparam logic [2:0] PH_SKIP  = 3'd2;
    localparam logic [2:0] PH_CMD   = 3'd3;
    localparam logic [2:0] PH_EXTRA = 3'd4;
    localparam logic [2:0] PH_LIT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [3:0] skip_reg, skip_next;
    logic [7:0] flag_hi_reg, flag_hi_next;
    logic [7:0] code_reg, code_next;
    logic [7:0] c2_reg, c2_next;
    logic [7:0] c3_reg, c3_next;
    logic [7:0] c4_reg, c4_next;
    logic [1:0] xcnt_reg, xcnt_next;
    logic [rpsd_pkg::LIT_W-1:0] lits_reg, lits_next;
    logic       accept;
    logic [3:0] skip_dec;
    logic [2:0] base_skip;
    logic [rpsd_pkg::LIT_W-1:0] lit_cnt;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign skip_dec = skip_reg - ((skip_reg != 4'd0) ? 4'd1 : 4'd0);
    assign base_skip = flag_hi_reg[7] ? 3'd4 : 3'd3;
    assign lit_cnt  = rpsd_pkg::literal_count(code_reg, c2_reg);

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        flag_hi_next = flag_hi_reg;
        code_next    = code_reg;
        c2_next      = c2_reg;
        c3_next      = c3_reg;
        c4_next      = c4_reg;
        xcnt_next    = xcnt_reg;
        lits_next    = lits_reg;
        cmd             = '0;
        cmd.back_dist   = rpsd_pkg::match_dist(code_reg, c2_reg, c3_reg);
        cmd.len         = rpsd_pkg::match_len(code_reg, c4_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (phase_reg)
                        PH_HDR0:
                        begin
                            flag_hi_next = in_byte;
                            phase_next   = PH_HDR1;
                        end
                        PH_HDR1:
                        begin
                            skip_next  = flag_hi_reg[0] ? {base_skip, 1'b0}
                                                        : {1'b0, base_skip};
                            phase_next = PH_SKIP;
                        end
                        PH_SKIP:
                        begin
                            skip_next = skip_dec;
                            if (skip_dec == 4'd0)
                                phase_next = PH_CMD;
                        end
                        PH_CMD:
                        begin
                            code_next = in_byte;
                            xcnt_next = 2'd0;
                            if (rpsd_pkg::extras_needed(in_byte) != 2'd0)
                                phase_next = PH_EXTRA;
                            else
                                state_next = ST_DISP;
                        end
                        PH_EXTRA:
                        begin
                            case (xcnt_reg)
                                2'd0:    c2_next = in_byte;
                                2'd1:    c3_next = in_byte;
                                default: c4_next = in_byte;
                            endcase
                            if ((xcnt_reg + 2'd1) >= rpsd_pkg::extras_needed(code_reg))
                            begin
                                xcnt_next  = 2'd0;
                                state_next = ST_DISP;
                            end
                            else
                                xcnt_next = xcnt_reg + 2'd1;
                        end
                        PH_LIT:
                        begin
                            cmd.lit_latch = 1'b1;
                            state_next    = ST_LIT;
                        end
                        default:
                            phase_next = PH_HDR0;
                    endcase
                end
            end
            ST_DISP:
            begin
                if (lit_cnt != '0)
                begin
                    lits_next  = lit_cnt;
                    phase_next = PH_LIT;
                    state_next = ST_IDLE;
                end
                else
                begin
                    phase_next = PH_CMD;
                    if (code_reg < rpsd_pkg::CODE_RUN)
                    begin
                        cmd.match_start = 1'b1;
                        state_next      = ST_MRD;
                    end
                    else
                        state_next = ST_END;
                end
            end
            ST_LIT:
            begin
                if (sts.out_free)
                begin
                    cmd.lit_emit = 1'b1;
                    lits_next    = lits_reg - rpsd_pkg::LIT_W'(1);
                    state_next   = ST_IDLE;
                    cmd.run_last = 1'b1;
                    if (lits_reg == rpsd_pkg::LIT_W'(1))
                    begin
                        phase_next = PH_CMD;
                        if (code_reg < rpsd_pkg::CODE_RUN)
                        begin
                            cmd.run_last    = 1'b0;
                            cmd.match_start = 1'b1;
                            state_next      = ST_MRD;
                        end
                        else if (code_reg >= rpsd_pkg::CODE_END)
                        begin
                            cmd.stream_end  = 1'b1;
                            cmd.clr_decoded = 1'b1;
                            phase_next      = PH_HDR0;
                        end
                    end
                end
            end
            ST_MRD:
                state_next = ST_MWR;
            ST_MWR:
            begin
                cmd.match_step = 1'b1;
                state_next     = sts.chunk_ready ? ST_MEMIT : ST_MRD;
            end
            ST_MEMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.match_emit = 1'b1;
                    cmd.run_last   = sts.match_done;
                    state_next     = sts.match_done ? ST_IDLE : ST_MRD;
                end
            end
            ST_END:
            begin
                if (sts.out_free)
                begin
                    cmd.end_emit    = 1'b1;
                    cmd.stream_end  = 1'b1;
                    cmd.run_last    = 1'b1;
                    cmd.clr_decoded = 1'b1;
                    phase_next      = PH_HDR0;
                    state_next      = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_HDR0;
            skip_reg    <= '0;
            flag_hi_reg <= '0;
            code_reg    <= '0;
            c2_reg      <= '0;
            c3_reg      <= '0;
            c4_reg      <= '0;
            xcnt_reg    <= '0;
            lits_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            skip_reg    <= skip_next;
            flag_hi_reg <= flag_hi_next;
            code_reg    <= code_next;
            c2_reg      <= c2_next;
            c3_reg      <= c3_next;
            c4_reg      <= c4_next;
            xcnt_reg    <= xcnt_next;
            lits_reg    <= lits_next;
        end
    end

endmodule

[hdl/rpsd_datapath.sv]
// Datapath: history memory, match copy engine, chunk buffer and output register.
module rpsd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_byte,
    input  rpsd_pkg::rpsd_cmd_t cmd,
    output rpsd_pkg::rpsd_sts_t sts,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [8*rpsd_pkg::LANES-1:0] out_data,
    output logic [rpsd_pkg::CNT_W-1:0]   out_count,
    output logic                out_run_last,
    output logic                out_stream_end,
    output logic                out_dist_err
);

    logic [7:0] hist_mem [rpsd_pkg::HIST_DEPTH];
    logic [7:0] rdata_reg;
    logic [7:0] lit_reg;
    logic [rpsd_pkg::HIST_AW-1:0] wp_reg;
    logic [rpsd_pkg::DEC_W-1:0]   dec_reg, dec_inc, dec_next;
    logic [rpsd_pkg::DIST_W-1:0]  dist_reg;
    logic [rpsd_pkg::LEN_W-1:0]   len_reg;
    logic                         err_reg;
    logic [rpsd_pkg::CNT_W-1:0]   fill_reg;
    logic [7:0] chunk_buf [rpsd_pkg::LANES];
    logic [rpsd_pkg::HIST_AW-1:0] raddr;
    logic       we;
    logic [7:0] wdata;
    logic       load;
    logic [8*rpsd_pkg::LANES-1:0] chunk_data;

    logic                         out_valid_reg;
    logic [8*rpsd_pkg::LANES-1:0] out_data_reg;
    logic [rpsd_pkg::CNT_W-1:0]   out_count_reg;
    logic                         run_last_reg;
    logic                         stream_end_reg;
    logic                         dist_err_reg;

    assign raddr = wp_reg - dist_reg[rpsd_pkg::HIST_AW-1:0];
    assign we    = cmd.lit_emit || cmd.match_step;
    assign wdata = cmd.lit_emit ? lit_reg : (err_reg ? 8'd0 : rdata_reg);
    assign load  = cmd.lit_emit || cmd.match_emit || cmd.end_emit;

    assign dec_inc = (dec_reg < rpsd_pkg::DEC_W'(rpsd_pkg::HIST_DEPTH))
                   ? dec_reg + rpsd_pkg::DEC_W'(1) : dec_reg;
    // the error check of a match sees the literal written in the same cycle
    assign dec_next = we ? dec_inc : dec_reg;

    assign sts.out_free    = !out_valid_reg || !out_stall;
    assign sts.chunk_ready = (fill_reg == rpsd_pkg::CNT_W'(rpsd_pkg::LANES - 1))
                          || (len_reg == rpsd_pkg::LEN_W'(1));
    assign sts.match_done  = (len_reg == '0);

    always_comb
    begin
        for (int i = 0; i < rpsd_pkg::LANES; i++)
            chunk_data[8*i +: 8] = (rpsd_pkg::CNT_W'(i) < fill_reg) ? chunk_buf[i] : 8'd0;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            hist_mem[wp_reg] <= wdata;
        rdata_reg <= hist_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lit_latch)
            lit_reg <= in_byte;
        if (cmd.match_step)
            chunk_buf[fill_reg[rpsd_pkg::FILL_AW-1:0]] <= wdata;
        if (cmd.match_start)
        begin
            dist_reg <= cmd.back_dist;
            err_reg  <= (cmd.back_dist > dec_next);
        end
        if (load)
        begin
            run_last_reg   <= cmd.run_last;
            stream_end_reg <= cmd.stream_end;
            if (cmd.lit_emit)
            begin
                out_data_reg  <= {{(8*rpsd_pkg::LANES-8){1'b0}}, lit_reg};
                out_count_reg <= rpsd_pkg::CNT_W'(1);
                dist_err_reg  <= 1'b0;
            end
            else if (cmd.match_emit)
            begin
                out_data_reg  <= chunk_data;
                out_count_reg <= fill_reg;
                dist_err_reg  <= err_reg;
            end
            else
            begin
                out_data_reg  <= '0;
                out_count_reg <= '0;
                dist_err_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            dec_reg       <= '0;
            len_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
                wp_reg <= wp_reg + rpsd_pkg::HIST_AW'(1);
            dec_reg <= cmd.clr_decoded ? '0 : dec_next;
            if (cmd.match_start)
                len_reg <= cmd.len;
            else if (cmd.match_step)
                len_reg <= len_reg - rpsd_pkg::LEN_W'(1);
            if (cmd.match_start || cmd.match_emit)
                fill_reg <= '0;
            else if (cmd.match_step)
                fill_reg <= fill_reg + rpsd_pkg::CNT_W'(1);
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;
    assign out_count      = out_count_reg;
    assign out_run_last   = run_last_reg;
    assign out_stream_end = stream_end_reg;
    assign out_dist_err   = dist_err_reg;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the streaming RefPack decompressor core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Decoder phases, kept in step with the block's own control flow.
    typedef enum int {PH_HDR0, PH_HDR1, PH_SKIP, PH_CMD, PH_EXTRA, PH_LIT} dec_phase_t;

    // One output chunk as the checker sees it; data holds byte 0 in the low bits.
    typedef struct {
        logic [255:0] data;
        logic [5:0]   cnt;
        logic         run_last;
        logic         stream_end;
        logic         dist_err;
    } chunk_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] bytes_0_7, bytes_8_15, bytes_16_23, bytes_24_31;
    logic [5:0]  byte_count;
    logic        run_last, stream_end, distance_error;

    refpack_stream_decompressor_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bytes_0_7      (bytes_0_7),
        .bytes_8_15     (bytes_8_15),
        .bytes_16_23    (bytes_16_23),
        .bytes_24_31    (bytes_24_31),
        .byte_count     (byte_count),
        .run_last       (run_last),
        .stream_end     (stream_end),
        .distance_error (distance_error)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder mirror: tracks header, command and history state per byte
    // and queues the chunks each accepted byte should produce.
    // ------------------------------------------------------------------
    dec_phase_t   phase = PH_HDR0;
    logic [15:0]  hdr_flags = '0;
    int unsigned  skip_left = 0;
    logic [31:0]  cmd_word = '0;
    int unsigned  lits_left = 0;
    int unsigned  decoded = 0;
    int unsigned  wr_ptr = 0;
    bit [7:0]     window [rpsd_pkg::HIST_DEPTH];
    chunk_t       chunk_q[$];

    int unsigned  n_bytes = 0;
    int unsigned  n_chunks = 0;
    int unsigned  n_err_chunks = 0;
    int unsigned  n_streams = 0;
    int unsigned  n_fail = 0;
    bit           idle_on = 1'b1;
    int unsigned  hold_cycles = 0;

    function automatic int unsigned extras_for(logic [7:0] code);
        if (code < rpsd_pkg::CODE_MEDIUM) return 1;
        if (code < rpsd_pkg::CODE_LONG)   return 2;
        if (code < rpsd_pkg::CODE_RUN)    return 3;
        return 0;
    endfunction

    function automatic void push_hist(logic [7:0] b);
        window[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % rpsd_pkg::HIST_DEPTH;
        if (decoded < rpsd_pkg::HIST_DEPTH)
            decoded++;
    endfunction

    function automatic void push_chunk(logic [255:0] d, int unsigned cnt, bit err);
        chunk_t c;
        c.data = d;
        c.cnt = cnt[5:0];
        c.run_last = 1'b0;
        c.stream_end = 1'b0;
        c.dist_err = err;
        chunk_q.push_back(c);
    endfunction

    function automatic void copy_back(int unsigned back_dist, int unsigned len);
        logic [255:0] d;
        int unsigned  c;
        bit           err;
        logic [7:0]   b;
        err = back_dist > decoded;
        while (len > 0) begin
            c = (len < rpsd_pkg::LANES) ? len : rpsd_pkg::LANES;
            d = '0;
            for (int i = 0; i < c; i++) begin
                b = err ? 8'h00 : window[(wr_ptr + rpsd_pkg::HIST_DEPTH - back_dist)
                                         % rpsd_pkg::HIST_DEPTH];
                d[8*i +: 8] = b;
                push_hist(b);
            end
            push_chunk(d, c, err);
            len -= c;
        end
    endfunction

    // nq: chunks already queued for this byte (end code marks the last of them)
    function automatic void close_command(int unsigned nq);
        logic [7:0] code, c2, c3, c4;
        {code, c2, c3, c4} = cmd_word;
        phase = PH_CMD;
        if (code < rpsd_pkg::CODE_MEDIUM)
            copy_back(c2 + ((code & 8'h60) << 3) + 1, ((code & 8'h1C) >> 2) + 3);
        else if (code < rpsd_pkg::CODE_LONG)
            copy_back(((c2 & 8'h3F) << 8) + c3 + 1, (code & 8'h3F) + 4);
        else if (code < rpsd_pkg::CODE_RUN)
            copy_back(((code & 8'h10) << 12) + (c2 << 8) + c3 + 1,
                      ((code & 8'h0C) << 6) + c4 + 5);
        else if (code >= rpsd_pkg::CODE_END) begin
            if (code[1:0] != 2'd0 && nq > 0)
                chunk_q[chunk_q.size()-1].stream_end = 1'b1;
            else begin
                push_chunk('0, 0, 1'b0);
                chunk_q[chunk_q.size()-1].stream_end = 1'b1;
            end
            phase = PH_HDR0;
            decoded = 0;
        end
    endfunction

    function automatic void open_command(int unsigned nq);
        logic [7:0] code, c2;
        code = cmd_word[31:24];
        c2 = cmd_word[23:16];
        if (code < rpsd_pkg::CODE_MEDIUM
            || (code >= rpsd_pkg::CODE_LONG && code < rpsd_pkg::CODE_RUN)
            || code >= rpsd_pkg::CODE_END)
            lits_left = code[1:0];
        else if (code < rpsd_pkg::CODE_LONG)
            lits_left = c2[7:6];
        else
            lits_left = (code[4:0] + 1) * 4;
        if (lits_left > 0)
            phase = PH_LIT;
        else
            close_command(nq);
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int unsigned base;
        int unsigned k;
        base = chunk_q.size();
        case (phase)
            PH_HDR0: begin
                hdr_flags = {b, 8'h00};
                phase = PH_HDR1;
            end
            PH_HDR1: begin
                hdr_flags[7:0] = b;
                skip_left = hdr_flags[15] ? 4 : 3;
                if (hdr_flags[8])
                    skip_left *= 2;
                phase = PH_SKIP;
            end
            PH_SKIP: begin
                if (skip_left > 0)
                    skip_left--;
                if (skip_left == 0)
                    phase = PH_CMD;
            end
            PH_CMD: begin
                cmd_word = {b, 24'h0};
                skip_left = 0;
                if (extras_for(b) > 0)
                    phase = PH_EXTRA;
                else
                    open_command(0);
            end
            PH_EXTRA: begin
                k = skip_left & 3;
                cmd_word[16 - 8*k +: 8] = b;
                skip_left = k + 1;
                if (skip_left >= extras_for(cmd_word[31:24])) begin
                    skip_left = 0;
                    open_command(0);
                end
            end
            PH_LIT: begin
                push_hist(b);
                push_chunk({248'h0, b}, 1, 1'b0);
                if (lits_left > 0)
                    lits_left--;
                if (lits_left == 0)
                    close_command(1);
            end
            default: phase = PH_HDR0;
        endcase
        if (chunk_q.size() > base)
            chunk_q[chunk_q.size()-1].run_last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transaction per call, random idle cycles up front.
    // valid stays high across back-to-back transactions.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while (idle_on && $urandom_range(0, 99) < 24) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b);
        n_bytes++;
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, plus a counted hold-off when requested.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end else
            out_stall <= idle_on && ($urandom_range(0, 99) < 24);
    end

    task automatic report_mismatch(input string what, input logic [255:0] got,
                                   input logic [255:0] want);
        n_fail++;
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    always @(posedge clk) begin
        chunk_t exp_c;
        if (rst_n && out_valid && !out_stall) begin
            if (chunk_q.size() == 0)
                report_mismatch("unexpected chunk, count", 256'(byte_count), 256'(0));
            else begin
                exp_c = chunk_q.pop_front();
                n_chunks++;
                if (exp_c.dist_err)
                    n_err_chunks++;
                if ({bytes_24_31, bytes_16_23, bytes_8_15, bytes_0_7} != exp_c.data)
                    report_mismatch("chunk bytes",
                                    {bytes_24_31, bytes_16_23, bytes_8_15, bytes_0_7},
                                    exp_c.data);
                if (byte_count != exp_c.cnt)
                    report_mismatch("byte_count", 256'(byte_count), 256'(exp_c.cnt));
                if (run_last != exp_c.run_last)
                    report_mismatch("run_last", 256'(run_last), 256'(exp_c.run_last));
                if (stream_end != exp_c.stream_end)
                    report_mismatch("stream_end", 256'(stream_end),
                                    256'(exp_c.stream_end));
                if (distance_error != exp_c.dist_err)
                    report_mismatch("distance_error", 256'(distance_error),
                                    256'(exp_c.dist_err));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stream building blocks
    // ------------------------------------------------------------------
    task automatic send_header(input logic [7:0] f0, input logic [7:0] f1);
        int unsigned n;
        n = f0[7] ? 4 : 3;
        if (f0[0])
            n *= 2;
        send_byte(f0);
        send_byte(f1);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        n_streams++;
    endtask

    task automatic send_literals(input int unsigned n);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Distance that mostly lands inside decoded data; now and then too far back.
    function automatic int unsigned pick_dist(int unsigned maxd, int unsigned lits);
        int unsigned avail;
        avail = decoded + lits;
        if (avail > maxd)
            avail = maxd;
        if (avail == 0 || $urandom_range(0, 19) == 0)
            return $urandom_range(1, maxd);
        return $urandom_range(1, avail);
    endfunction

    task automatic send_short(input int unsigned lits, input int unsigned back_dist,
                              input int unsigned len);
        send_byte(8'((((back_dist - 1) >> 8) << 5) | ((len - 3) << 2) | lits));
        send_byte(8'((back_dist - 1) & 8'hFF));
        send_literals(lits);
    endtask

    task automatic send_medium(input int unsigned lits, input int unsigned back_dist,
                               input int unsigned len);
        send_byte(8'(rpsd_pkg::CODE_MEDIUM | (len - 4)));
        send_byte(8'((lits << 6) | ((back_dist - 1) >> 8)));
        send_byte(8'((back_dist - 1) & 8'hFF));
        send_literals(lits);
    endtask

    task automatic send_long(input int unsigned lits, input int unsigned back_dist,
                             input int unsigned len);
        send_byte(8'(rpsd_pkg::CODE_LONG | (((back_dist - 1) >> 16) << 4)
                     | (((len - 5) >> 8) << 2) | lits));
        send_byte(8'(((back_dist - 1) >> 8) & 8'hFF));
        send_byte(8'((back_dist - 1) & 8'hFF));
        send_byte(8'((len - 5) & 8'hFF));
        send_literals(lits);
    endtask

    task automatic send_run(input int unsigned k);
        send_byte(8'(rpsd_pkg::CODE_RUN | k));
        send_literals((k + 1) * 4);
    endtask

    task automatic send_end(input int unsigned lits);
        send_byte(8'(rpsd_pkg::CODE_END | lits));
        send_literals(lits);
    endtask

    // Drive the decoder back to the header phase from wherever noise left it.
    task automatic resync();
        while (phase != PH_HDR0)
            send_byte(phase == PH_CMD ? rpsd_pkg::CODE_END : 8'h00);
    endtask

    task automatic drain();
        stop_sending();
        while (chunk_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every command form, far distances and both end forms.
    task automatic test_directed();
        send_header(8'hFF, 8'hFF);
        send_short(0, 1, 3);          // reaches before any data
        send_run(0);
        send_short(3, 1, 10);
        send_medium(2, 16384, 67);    // too far back
        send_long(1, 4, 5);
        send_end(0);                  // end with no literals: empty chunk
        send_header(8'h00, 8'h00);
        send_run(27);                 // longest literal run
        send_long(3, 120, 1028);      // longest match, most chunks per byte
        send_long(0, 131072, 5);      // farthest distance
        send_end(3);
        drain();
    endtask

    // Receiver holds off while the sender keeps offering a long run.
    task automatic test_backpressure();
        send_header(8'h10, 8'h00);
        hold_cycles = 300;
        send_run(27);
        send_medium(0, 50, 60);
        send_end(1);
        drain();
    endtask

    task automatic random_command();
        int unsigned kind, lits;
        kind = $urandom_range(0, 9);
        lits = $urandom_range(0, 3);
        case (kind)
            0, 1, 2: send_short(lits, pick_dist(1024, lits), $urandom_range(3, 10));
            3, 4:    send_medium(lits, pick_dist(16384, lits), $urandom_range(4, 67));
            5, 6:    send_long(lits, pick_dist(131072, lits),
                               ($urandom_range(0, 15) == 0) ? $urandom_range(5, 1028)
                                                            : $urandom_range(5, 40));
            7, 8:    send_run(($urandom_range(0, 3) == 0) ? $urandom_range(0, 27)
                                                          : $urandom_range(0, 3));
            default: send_literals(0);
        endcase
    endtask

    // Mostly well-formed streams with random content; some raw noise.
    task automatic test_random(input int unsigned target);
        while (n_bytes < target) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
                resync();
            end else begin
                send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 6)) random_command();
                send_end($urandom_range(0, 3));
            end
        end
        drain();
    endtask

    // Same traffic with both sides running flat out.
    task automatic test_no_idle();
        idle_on = 1'b0;
        test_random(n_bytes + 60);
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(200);
        test_no_idle();
        test_random(310);
        $display("Covered %0d input bytes in %0d streams, %0d chunks checked (%0d flagged too far).",
                 n_bytes, n_streams, n_chunks, n_err_chunks);
        $display("All command forms, header variants, stalls and a long output hold-off exercised.");
        if (n_fail == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #40000000;
        $display("Timeout with %0d chunks outstanding", chunk_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
hdl/rpsd_pkg.sv
hdl/rpsd_ctrl.sv
hdl/rpsd_datapath.sv
hdl/refpack_stream_decompressor_core.sv
tb/sv/tb_top.sv
